// ----- hw/rtl/qllm_pkg.sv -----
// Package for the quantized level-line map: configuration struct, register
// indexes, result codes and state machine types.
// No dependencies.
`timescale 1ns / 1ps

package qllm_pkg;

  localparam int unsigned PIX_W = 8;

  // Result codes
  localparam logic [PIX_W-1:0] CODE_NONE = 8'd255;
  localparam logic [PIX_W-1:0] CODE_LEFT = 8'd200;
  localparam logic [PIX_W-1:0] CODE_UP   = 8'd100;
  localparam logic [PIX_W-1:0] CODE_BOTH = 8'd0;

  // Configuration register indexes
  typedef enum logic [1:0] {
    REG_QUANT_DIV    = 2'd0,
    REG_BORDER_TYPED = 2'd1,
    REG_LINE_WIDTH   = 2'd2
  } cfg_reg_t;

  // Configuration register reset values
  localparam logic [7:0]  QUANT_DIV_RST  = 8'd20;
  localparam logic [12:0] LINE_WIDTH_RST = 13'd640;

  // Configuration as seen by the front and back parts
  typedef struct packed {
    logic [7:0]  quant_div;
    logic        border_typed;
    logic [12:0] line_width;
  } cfg_t;

  // Front: accept, divide, hand over
  typedef enum logic [1:0] {
    FR_IDLE,
    FR_DIV,
    FR_PUSH
  } front_state_t;

  // Back: fetch the row above, evaluate and emit
  typedef enum logic {
    BK_IDLE,
    BK_EVAL
  } back_state_t;

endpackage

// ----- hw/rtl/quantized_level_line_map_top.sv -----
// Quantized level-line map: top level with configuration registers, front,
// queue and back parts. Depends on qllm_pkg, qllm_front, qllm_fifo, qllm_back.
//
// Usage: gray pixels enter in raster order on the in_ stream (tdata = pixel,
// tuser = start of frame). Each pixel is divided by the quantization step and
// compared with the quantized pixel above (from a line store of MAX_WIDTH
// entries) and with the previous pixel in raster order; one map code leaves on
// the out_ stream per pixel. Registers are written through
// cfg_we/cfg_addr/cfg_wdata; the user must do so only while the block is
// idle, which the block itself does not enforce. A new pixel is taken only
// after the bit-serial divider has finished and the last one is in the queue.
// Path: accept, division, hand-over to the queue, pop with line-store read
// in the back part, then evaluation into the output register.
// Reset clears the column counter, marks the first row, zeroes the left
// neighbor and loads the register defaults; the line store is not cleared.
// When the receiver stalls, the result waits in the output register, the
// two-entry queue fills, and then the input side stops accepting.
`timescale 1ns / 1ps

module quantized_level_line_map_top #(
  parameter int unsigned MAX_WIDTH = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  // Pixel input
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] pixel
  input  logic        in_tuser,   // [0] start_of_frame
  // Map code output
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [7:0]  out_tdata,  // [7:0] map_code
  // Configuration
  input  logic        cfg_we,
  input  logic [1:0]  cfg_addr,
  input  logic [12:0] cfg_wdata
);

  localparam int unsigned DW = qllm_pkg::PIX_W + $clog2(MAX_WIDTH) + 1;

  qllm_pkg::cfg_t cfg_r, cfg_nxt;
  logic           push, pop, q_full, q_empty;
  logic [DW-1:0]  push_data, head;

  // Register writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_addr)
        qllm_pkg::REG_QUANT_DIV:    cfg_nxt.quant_div    = cfg_wdata[7:0];
        qllm_pkg::REG_BORDER_TYPED: cfg_nxt.border_typed = cfg_wdata[0];
        qllm_pkg::REG_LINE_WIDTH:   cfg_nxt.line_width   = cfg_wdata;
        default:                    cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.quant_div    <= qllm_pkg::QUANT_DIV_RST;
      cfg_r.border_typed <= 1'b0;
      cfg_r.line_width   <= qllm_pkg::LINE_WIDTH_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  qllm_front #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg            (cfg_r),
    .in_valid       (in_tvalid),
    .in_ready       (in_tready),
    .pixel          (in_tdata),
    .start_of_frame (in_tuser),
    .push           (push),
    .q_full         (q_full),
    .push_data      (push_data)
  );

  qllm_fifo #(
    .DW(DW)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .full      (q_full),
    .empty     (q_empty)
  );

  qllm_back #(
    .MAX_WIDTH(MAX_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .head      (head),
    .empty     (q_empty),
    .pop       (pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .map_code  (out_tdata)
  );

endmodule

// ----- hw/rtl/qllm_front.sv -----
// Front part: accepts pixels, tracks column and first row, and quantizes
// with a bit-serial restoring divider. Depends on qllm_pkg.
`timescale 1ns / 1ps

module qllm_front #(
  parameter int unsigned MAX_WIDTH = 4096
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  qllm_pkg::cfg_t                         cfg,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic [qllm_pkg::PIX_W-1:0]             pixel,
  input  logic                                   start_of_frame,
  output logic                                   push,
  input  logic                                   q_full,
  output logic [qllm_pkg::PIX_W+$clog2(MAX_WIDTH):0] push_data
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned WW = $clog2(MAX_WIDTH + 1);

  qllm_pkg::front_state_t state_r, state_nxt;
  logic [CW-1:0]              col_r, col_nxt;
  logic                       first_r, first_nxt;
  logic [qllm_pkg::PIX_W-1:0] dvd_r, dvd_nxt;
  logic [qllm_pkg::PIX_W-1:0] rem_r, rem_nxt;
  logic [qllm_pkg::PIX_W-1:0] quo_r, quo_nxt;
  logic [2:0]                 cnt_r, cnt_nxt;
  logic [CW-1:0]              ent_col_r, ent_col_nxt;
  logic                       ent_first_r, ent_first_nxt;

  logic [31:0]                lw32, eff32;
  logic [WW-1:0]              eff_w;
  logic [CW-1:0]              col_start, col_use;
  logic [WW-1:0]              col_inc;
  logic                       first_use;
  logic [qllm_pkg::PIX_W-1:0] divisor;
  logic [qllm_pkg::PIX_W:0]   trial;
  logic                       fits;
  logic                       accept;

  // Effective row width: zero acts as one, saturate at MAX_WIDTH
  always_comb begin
    lw32 = 32'(cfg.line_width);
    if (lw32 == 32'd0) begin
      eff32 = 32'd1;
    end else if (lw32 > 32'(MAX_WIDTH)) begin
      eff32 = 32'(MAX_WIDTH);
    end else begin
      eff32 = lw32;
    end
    eff_w = eff32[WW-1:0];
  end

  // Column and first-row flag for the incoming pixel
  always_comb begin
    col_start = start_of_frame ? '0 : col_r;
    first_use = start_of_frame | first_r;
    col_use   = (WW'(col_start) >= eff_w) ? '0 : col_start;
    col_inc   = WW'(col_use) + WW'(1);
  end

  // One quotient bit per cycle
  assign divisor = (cfg.quant_div == '0) ? 8'd1 : cfg.quant_div;
  assign trial   = {rem_r, dvd_r[qllm_pkg::PIX_W-1]};
  assign fits    = trial >= {1'b0, divisor};

  assign in_ready  = rst_n && (state_r == qllm_pkg::FR_IDLE);
  assign accept    = in_valid && in_ready;
  assign push      = (state_r == qllm_pkg::FR_PUSH) && !q_full;
  assign push_data = {ent_first_r, ent_col_r, quo_r};

  // Next state and datapath
  always_comb begin
    state_nxt     = state_r;
    col_nxt       = col_r;
    first_nxt     = first_r;
    dvd_nxt       = dvd_r;
    rem_nxt       = rem_r;
    quo_nxt       = quo_r;
    cnt_nxt       = cnt_r;
    ent_col_nxt   = ent_col_r;
    ent_first_nxt = ent_first_r;
    unique case (state_r)
      qllm_pkg::FR_IDLE: begin
        if (accept) begin
          dvd_nxt       = pixel;
          rem_nxt       = '0;
          quo_nxt       = '0;
          cnt_nxt       = '0;
          ent_col_nxt   = col_use;
          ent_first_nxt = first_use;
          if (col_inc >= eff_w) begin
            col_nxt   = '0;
            first_nxt = 1'b0;
          end else begin
            col_nxt   = col_inc[CW-1:0];
            first_nxt = first_use;
          end
          state_nxt = qllm_pkg::FR_DIV;
        end
      end
      qllm_pkg::FR_DIV: begin
        rem_nxt = fits ? 8'(trial - {1'b0, divisor}) : trial[qllm_pkg::PIX_W-1:0];
        quo_nxt = {quo_r[qllm_pkg::PIX_W-2:0], fits};
        dvd_nxt = {dvd_r[qllm_pkg::PIX_W-2:0], 1'b0};
        cnt_nxt = cnt_r + 3'd1;
        if (cnt_r == 3'd7) begin
          state_nxt = qllm_pkg::FR_PUSH;
        end
      end
      qllm_pkg::FR_PUSH: begin
        if (!q_full) begin
          state_nxt = qllm_pkg::FR_IDLE;
        end
      end
      default: state_nxt = qllm_pkg::FR_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= qllm_pkg::FR_IDLE;
      col_r   <= '0;
      first_r <= 1'b1;
    end else begin
      state_r <= state_nxt;
      col_r   <= col_nxt;
      first_r <= first_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    dvd_r       <= dvd_nxt;
    rem_r       <= rem_nxt;
    quo_r       <= quo_nxt;
    cnt_r       <= cnt_nxt;
    ent_col_r   <= ent_col_nxt;
    ent_first_r <= ent_first_nxt;
  end

endmodule

// ----- hw/rtl/qllm_fifo.sv -----
// Two-entry queue between the front and back parts.
// Depends on nothing outside this file.
`timescale 1ns / 1ps

module qllm_fifo #(
  parameter int unsigned DW = 21
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  logic [DW-1:0] push_data,
  input  logic          pop,
  output logic [DW-1:0] head,
  output logic          full,
  output logic          empty
);

  logic [DW-1:0] slot_r [2];
  logic          wr_ptr_r, wr_ptr_nxt;
  logic          rd_ptr_r, rd_ptr_nxt;
  logic [1:0]    count_r, count_nxt;

  assign full  = count_r == 2'd2;
  assign empty = count_r == 2'd0;
  assign head  = slot_r[rd_ptr_r];

  // Advance pointers and count
  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

// ----- hw/rtl/qllm_back.sv -----
// Back part: reads the row above from the line store, compares with the
// left neighbor, writes the store and drives the output register.
// Depends on qllm_pkg.
`timescale 1ns / 1ps

module qllm_back #(
  parameter int unsigned MAX_WIDTH = 4096
) (
  input  logic                                       clk,
  input  logic                                       rst_n,
  input  qllm_pkg::cfg_t                             cfg,
  input  logic [qllm_pkg::PIX_W+$clog2(MAX_WIDTH):0] head,
  input  logic                                       empty,
  output logic                                       pop,
  output logic                                       out_valid,
  input  logic                                       out_ready,
  output logic [qllm_pkg::PIX_W-1:0]                 map_code
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);

  qllm_pkg::back_state_t state_r, state_nxt;
  logic [qllm_pkg::PIX_W-1:0] line_mem [MAX_WIDTH];
  logic [qllm_pkg::PIX_W-1:0] q_r, up_r;
  logic [CW-1:0]              col_r;
  logic                       first_r;
  logic [qllm_pkg::PIX_W-1:0] prev_r, prev_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic [qllm_pkg::PIX_W-1:0] out_data_r, out_data_nxt;

  logic [qllm_pkg::PIX_W-1:0] head_q;
  logic [CW-1:0]              head_col;
  logic                       head_first;
  logic                       load;
  logic                       left_ne, up_ne;
  logic [qllm_pkg::PIX_W-1:0] code;

  assign {head_first, head_col, head_q} = head;
  assign out_valid = out_valid_r;
  assign map_code  = out_data_r;

  // Classify against left and upper neighbors
  assign left_ne = prev_r != q_r;
  assign up_ne   = up_r != q_r;
  always_comb begin
    if (first_r) begin
      code = qllm_pkg::CODE_NONE;
    end else if (cfg.border_typed) begin
      unique case ({left_ne, up_ne})
        2'b11:   code = qllm_pkg::CODE_BOTH;
        2'b10:   code = qllm_pkg::CODE_LEFT;
        2'b01:   code = qllm_pkg::CODE_UP;
        default: code = qllm_pkg::CODE_NONE;
      endcase
    end else begin
      code = (left_ne || up_ne) ? qllm_pkg::CODE_BOTH : qllm_pkg::CODE_NONE;
    end
  end

  // Next state and outputs
  always_comb begin
    state_nxt     = state_r;
    pop           = 1'b0;
    load          = 1'b0;
    prev_nxt      = prev_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;
    unique case (state_r)
      qllm_pkg::BK_IDLE: begin
        if (!empty) begin
          pop       = 1'b1;
          state_nxt = qllm_pkg::BK_EVAL;
        end
      end
      qllm_pkg::BK_EVAL: begin
        if (!out_valid_r || out_ready) begin
          load          = 1'b1;
          out_valid_nxt = 1'b1;
          out_data_nxt  = code;
          prev_nxt      = q_r;
          state_nxt     = qllm_pkg::BK_IDLE;
        end
      end
      default: state_nxt = qllm_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= qllm_pkg::BK_IDLE;
      prev_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      prev_r      <= prev_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Hold the popped entry and the result payload
  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
    if (pop) begin
      q_r     <= head_q;
      col_r   <= head_col;
      first_r <= head_first;
    end
  end

  // Line store: registered read at pop, write when the result enters the output register
  always_ff @(posedge clk) begin
    if (pop) begin
      up_r <= line_mem[head_col];
    end
    if (load) begin
      line_mem[col_r] <= q_r;
    end
  end

endmodule

// ----- hw/rtl/qllm_checker.sv -----
// Port-level checker for the quantized level-line map, bound to the top.
// Depends on qllm_pkg and quantized_level_line_map_top.
`timescale 1ns / 1ps

module qllm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [7:0]  out_tdata
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed or dropped while stalled");

  // Only the four codes appear
  a_code_set: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata == qllm_pkg::CODE_NONE) ||
                   (out_tdata == qllm_pkg::CODE_LEFT) ||
                   (out_tdata == qllm_pkg::CODE_UP) ||
                   (out_tdata == qllm_pkg::CODE_BOTH))
    else $error("map code outside the code set");

  // Divider is busy right after an accept
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input ready while divider busy");

  // Reset empties the output
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

endmodule

bind quantized_level_line_map_top qllm_checker u_qllm_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

// ----- sim/tb_quantized_level_line_map_top.sv -----
// Self-checking testbench for quantized_level_line_map_top: streams pixel frames
// through the block under random stalls on both sides and compares every map code.
// Depends on qllm_pkg and the RTL of quantized_level_line_map_top.
`timescale 1ns / 1ps

module tb_quantized_level_line_map_top;

  localparam int unsigned LINE_MAX    = 4096;
  localparam int unsigned QUIET_LIMIT = 2000;

  typedef struct {
    logic [7:0]  pixel;
    logic        sof;
    int unsigned gap;
  } pixel_item_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;   // [7:0] pixel
  logic        in_tuser = 1'b0; // [0] start_of_frame
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;       // [7:0] map_code
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_addr = '0;
  logic [12:0] cfg_wdata = '0;

  pixel_item_t pixels_pending[$];
  logic [7:0]  codes_due[$];
  int unsigned idle_max = 7;
  int unsigned in_wait = 0;
  int unsigned rx_wait = 0;
  int unsigned codes_seen = 0;
  int unsigned next_hold = 100;
  int unsigned quiet_cycles = 0;
  int unsigned mismatches = 0;
  bit          sof_owed = 1'b0;

  // Shadow of the block: configuration, line of quantized values, raster position
  logic [7:0]  m_step = qllm_pkg::QUANT_DIV_RST;
  logic        m_typed = 1'b0;
  logic [12:0] m_width = qllm_pkg::LINE_WIDTH_RST;
  logic [7:0]  above_q [LINE_MAX];
  logic [7:0]  prev_q = '0;
  int unsigned col_now = 0;
  bit          first_row = 1'b1;

  quantized_level_line_map_top #(.MAX_WIDTH(LINE_MAX)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  always #6 clk = ~clk;

  // Zero width acts as one pixel, anything past the line store saturates
  function automatic int unsigned eff_width(input logic [12:0] w);
    if (w == 0) return 1;
    if (w > LINE_MAX) return LINE_MAX;
    return 32'(w);
  endfunction

  // Quantize one pixel, compare with left and upper neighbors, advance position
  function automatic logic [7:0] code_for_pixel(input logic [7:0] pix, input logic sof);
    logic [7:0]  divisor;
    logic [7:0]  q;
    logic [7:0]  up_q;
    logic [7:0]  code;
    int unsigned w;
    divisor = (m_step == 0) ? 8'd1 : m_step;
    w = eff_width(m_width);
    if (sof) begin
      col_now = 0;
      first_row = 1'b1;
    end
    if (col_now >= w) col_now = 0;
    q = pix / divisor;
    up_q = above_q[col_now];
    if (first_row) begin
      code = qllm_pkg::CODE_NONE;
    end else if (m_typed) begin
      if (prev_q == q && up_q == q) code = qllm_pkg::CODE_NONE;
      else if (prev_q != q && up_q != q) code = qllm_pkg::CODE_BOTH;
      else if (prev_q != q) code = qllm_pkg::CODE_LEFT;
      else code = qllm_pkg::CODE_UP;
    end else begin
      code = (prev_q != q || up_q != q) ? qllm_pkg::CODE_BOTH : qllm_pkg::CODE_NONE;
    end
    above_q[col_now] = q;
    prev_q = q;
    col_now++;
    if (col_now >= w) begin
      col_now = 0;
      first_row = 1'b0;
    end
    return code;
  endfunction

  // Pixel driver: predict on accept, then offer the next item after its gap
  always @(posedge clk) begin : pixel_driver
    pixel_item_t it;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_wait = 0;
    end else begin
      if (in_tvalid && in_tready)
        codes_due.push_back(code_for_pixel(in_tdata, in_tuser));
      if (!in_tvalid || in_tready) begin
        if (pixels_pending.size() != 0 && in_wait >= pixels_pending[0].gap) begin
          it = pixels_pending.pop_front();
          in_tdata  <= it.pixel;
          in_tuser  <= it.sof;
          in_tvalid <= 1'b1;
          in_wait = 0;
        end else begin
          in_tvalid <= 1'b0;
          if (pixels_pending.size() != 0) in_wait++;
        end
      end
    end
  end

  // Code monitor: check each accepted map code, then draw the next stall
  always @(posedge clk) begin : code_monitor
    logic [7:0] want;
    if (!rst_n) begin
      out_tready <= 1'b0;
      rx_wait = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (codes_due.size() == 0) begin
          $error("map_code: unexpected item, actual %0d", out_tdata);
          mismatches++;
        end else begin
          want = codes_due.pop_front();
          if (out_tdata !== want) begin
            $error("map_code: expected %0d, actual %0d", want, out_tdata);
            mismatches++;
          end
        end
        codes_seen++;
        // hold off long enough for the queue to fill and the input to stall
        if (codes_seen >= next_hold && pixels_pending.size() >= 8) begin
          rx_wait = 150;
          next_hold += 250;
        end else begin
          rx_wait = $urandom_range(0, idle_max);
        end
      end
      if (rx_wait != 0) begin
        out_tready <= 1'b0;
        rx_wait--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // Write one register; a wider line forces a new frame so no stale column is read
  task automatic write_reg(input qllm_pkg::cfg_reg_t idx, input logic [12:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    case (idx)
      qllm_pkg::REG_QUANT_DIV:    m_step = val[7:0];
      qllm_pkg::REG_BORDER_TYPED: m_typed = val[0];
      qllm_pkg::REG_LINE_WIDTH: begin
        if (eff_width(val) > eff_width(m_width)) sof_owed = 1'b1;
        m_width = val;
      end
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic queue_pixel(input logic [7:0] pix, input logic sof);
    pixel_item_t it;
    it.pixel = pix;
    it.sof   = sof | sof_owed;
    it.gap   = $urandom_range(0, idle_max);
    sof_owed = 1'b0;
    pixels_pending.push_back(it);
  endtask

  // Wait until every item is accepted and every code has come back; sample
  // between edges so the driver's updates of the current edge are visible
  task automatic drain();
    @(negedge clk);
    while (pixels_pending.size() != 0 || in_tvalid || codes_due.size() != 0)
      @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  initial begin : stimulus
    logic [7:0]  palette [3];
    logic [7:0]  pix;
    int unsigned n_items;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Register defaults, stream opens without a start mark
    queue_pixel(8'd0, 1'b0);
    queue_pixel(8'd255, 1'b0);
    queue_pixel(8'd37, 1'b0);
    drain();

    // Typed codes on a four-pixel line: none, left, up and both
    write_reg(qllm_pkg::REG_QUANT_DIV, 13'd1);
    write_reg(qllm_pkg::REG_BORDER_TYPED, 13'd1);
    write_reg(qllm_pkg::REG_LINE_WIDTH, 13'd4);
    foreach (palette[i]) palette[i] = 8'd0;
    queue_pixel(8'd0, 1'b1);
    queue_pixel(8'd255, 1'b0);
    queue_pixel(8'd255, 1'b0);
    queue_pixel(8'd7, 1'b0);
    queue_pixel(8'd0, 1'b0);
    queue_pixel(8'd255, 1'b0);
    queue_pixel(8'd255, 1'b0);
    queue_pixel(8'd255, 1'b0);
    queue_pixel(8'd1, 1'b0);
    queue_pixel(8'd1, 1'b0);
    queue_pixel(8'd200, 1'b0);
    queue_pixel(8'd200, 1'b0);
    drain();

    // Zero step and zero width in plain mode, mid-frame
    write_reg(qllm_pkg::REG_QUANT_DIV, 13'd0);
    write_reg(qllm_pkg::REG_BORDER_TYPED, 13'd0);
    write_reg(qllm_pkg::REG_LINE_WIDTH, 13'd0);
    queue_pixel(8'd0, 1'b0);
    queue_pixel(8'd0, 1'b0);
    queue_pixel(8'd255, 1'b0);
    queue_pixel(8'd255, 1'b0);
    queue_pixel(8'd128, 1'b0);
    drain();

    // Random phases; one of them saturates the line width
    for (int p = 0; p < 14; p++) begin
      if (p == 4) begin
        idle_max = 0;
        write_reg(qllm_pkg::REG_LINE_WIDTH, 13'h1FFF);
        write_reg(qllm_pkg::REG_QUANT_DIV, 13'd255);
        write_reg(qllm_pkg::REG_BORDER_TYPED, 13'($urandom_range(0, 1)));
        n_items = 40;
        palette[0] = 8'd0;
        palette[1] = 8'd255;
        palette[2] = 8'd254;
      end else begin
        idle_max = ($urandom_range(0, 3) == 0) ? 0 : 7;
        case ($urandom_range(0, 5))
          0: write_reg(qllm_pkg::REG_QUANT_DIV, 13'd0);
          1: write_reg(qllm_pkg::REG_QUANT_DIV, 13'd1);
          2: write_reg(qllm_pkg::REG_QUANT_DIV, 13'd255);
          default: write_reg(qllm_pkg::REG_QUANT_DIV, 13'($urandom_range(2, 64)));
        endcase
        write_reg(qllm_pkg::REG_BORDER_TYPED, 13'($urandom_range(0, 1)));
        if ($urandom_range(0, 3) != 0) begin
          case ($urandom_range(0, 5))
            0: write_reg(qllm_pkg::REG_LINE_WIDTH, 13'd1);
            1: write_reg(qllm_pkg::REG_LINE_WIDTH, 13'd2);
            2: write_reg(qllm_pkg::REG_LINE_WIDTH, 13'd4096);
            default: write_reg(qllm_pkg::REG_LINE_WIDTH, 13'($urandom_range(3, 12)));
          endcase
        end
        n_items = $urandom_range(30, 50);
        foreach (palette[i]) palette[i] = 8'($urandom_range(0, 255));
      end
      // mostly a few palette levels so neighbors often quantize alike
      for (int unsigned k = 0; k < n_items; k++) begin
        pix = ($urandom_range(0, 2) != 0) ? palette[$urandom_range(0, 2)]
                                          : 8'($urandom_range(0, 255));
        if (k == 0) queue_pixel(pix, 1'($urandom_range(0, 1)));
        else queue_pixel(pix, 1'($urandom_range(0, 39) == 0));
      end
      drain();
    end

    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hw/rtl/qllm_pkg.sv
hw/rtl/qllm_front.sv
hw/rtl/qllm_fifo.sv
hw/rtl/qllm_back.sv
hw/rtl/quantized_level_line_map_top.sv
hw/rtl/qllm_checker.sv
sim/tb_quantized_level_line_map_top.sv
